/* rtl/core/union_find_set_merger_unit_assert.svh */
// Assertion macros for the union-find set merger.
`ifndef UNION_FIND_SET_MERGER_UNIT_ASSERT_SVH
`define UNION_FIND_SET_MERGER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define UFSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufsm same-cycle check failed");
`define UFSM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufsm next-cycle check failed");
`else
`define UFSM_ASSERT_NOW(lbl, ante, cons)
`define UFSM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/ufsm_pkg.sv */
// Shared types and constants of the union-find set merger.
package ufsm_pkg;

    localparam int unsigned IDX_W  = 15;
    localparam int unsigned SIZE_W = 16;
    localparam int unsigned CNT_W  = 15;

    localparam logic [SIZE_W-1:0] SIZE_ONE = 16'd1;
    localparam logic [SIZE_W-1:0] SIZE_SAT = 16'hFFFF;

    typedef struct packed {
        logic [IDX_W-1:0] node_a;
        logic [IDX_W-1:0] node_b;
    } join_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  root;
        logic              merged;
        logic [SIZE_W-1:0] root_size;
        logic [CNT_W-1:0]  group_count;
    } result_t;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_REDUCE = 6'b000100,
        ST_WALK_A = 6'b001000,
        ST_WALK_B = 6'b010000,
        ST_UPDATE = 6'b100000
    } state_t;

endpackage

/* rtl/core/union_find_set_merger_unit.sv */
// Top level of the union-find set merger: control sequencer and node tables.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------
//  join_req  | start, busy        | node_a, node_b
//  result    | done (one cycle)   | root, merged, root_size, group_count
//
// An item walks from node_a and then from node_b to their roots, one parent
// link per read; the depth of a node is its number of parent links to its root
// (at most log2(NODES)); the single parent-table read port sets this pace.
// After reset, with busy high, every node is set up as a root of size one.
// A new start is taken while done is high; result holds until the next done.
`include "union_find_set_merger_unit_assert.svh"

module union_find_set_merger_unit #(
    parameter int unsigned NODES = 32768
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ufsm_pkg::join_req_t join_req,
    output logic                done,
    output ufsm_pkg::result_t   result
);

    localparam int unsigned IW = $clog2(NODES);
    localparam int unsigned SW = ufsm_pkg::SIZE_W;
    localparam int unsigned CW = ufsm_pkg::CNT_W;
    localparam logic [IW-1:0] LAST_NODE = IW'(NODES - 1);
    localparam logic [IW:0]   NODE_LIM  = (IW + 1)'(NODES);

    ufsm_pkg::state_t  state_reg, state_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     ra_reg, ra_next;
    logic [IW-1:0]     rb_reg, rb_next;
    logic [SW-1:0]     sa_reg, sa_next;
    logic [SW-1:0]     sb_reg, sb_next;
    logic [CW-1:0]     multi_reg, multi_next;
    logic              done_reg, done_next;
    ufsm_pkg::result_t result_reg, result_next;

    logic          red_load, red_done;
    logic [IW-1:0] red_a, red_b;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] parent_q;
    logic [SW-1:0] size_q;
    logic          pw_en, sw_en;
    logic [IW-1:0] pw_addr, pw_data, sw_addr;
    logic [SW-1:0] sw_data;

    logic          at_root;
    logic          same_root;
    logic          b_wins;
    logic [IW-1:0] win_root, lose_root;
    logic [SW-1:0] win_size, lose_size;
    logic [SW:0]   size_sum;
    logic [SW-1:0] size_sat;
    logic [CW-1:0] multi_inc, multi_upd;

    ufsm_idx_reduce #(
        .NODES (NODES),
        .IW    (IW)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (red_load),
        .a_in  (join_req.node_a),
        .b_in  (join_req.node_b),
        .done  (red_done),
        .a_out (red_a),
        .b_out (red_b)
    );

    ufsm_ram #(
        .DEPTH (NODES),
        .WIDTH (IW)
    ) u_parent_ram (
        .clk   (clk),
        .we    (pw_en),
        .waddr (pw_addr),
        .wdata (pw_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (parent_q)
    );

    ufsm_ram #(
        .DEPTH (NODES),
        .WIDTH (SW)
    ) u_size_ram (
        .clk   (clk),
        .we    (sw_en),
        .waddr (sw_addr),
        .wdata (sw_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (size_q)
    );

    // A node that links to itself, or outside the table, is a root.
    assign at_root = (parent_q == cur_reg) || ({1'b0, parent_q} >= NODE_LIM);

    assign same_root = (ra_reg == rb_reg);
    assign b_wins    = (sb_reg > sa_reg);
    assign win_root  = b_wins ? rb_reg : ra_reg;
    assign lose_root = b_wins ? ra_reg : rb_reg;
    assign win_size  = b_wins ? sb_reg : sa_reg;
    assign lose_size = b_wins ? sa_reg : sb_reg;
    assign size_sum  = {1'b0, sa_reg} + {1'b0, sb_reg};
    assign size_sat  = size_sum[SW] ? ufsm_pkg::SIZE_SAT : size_sum[SW-1:0];

    // Two singletons make a new group; two groups collapse into one.
    assign multi_inc = (win_size == ufsm_pkg::SIZE_ONE) ? CW'(multi_reg + 1'b1) : multi_reg;
    assign multi_upd = (lose_size > ufsm_pkg::SIZE_ONE) ? CW'(multi_inc - 1'b1) : multi_inc;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cur_next    = cur_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        multi_next  = multi_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        red_load    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = cur_reg;
        pw_en       = 1'b0;
        pw_addr     = clr_reg;
        pw_data     = clr_reg;
        sw_en       = 1'b0;
        sw_addr     = clr_reg;
        sw_data     = ufsm_pkg::SIZE_ONE;

        case (state_reg)
            ufsm_pkg::ST_CLEAR:
            begin
                pw_en    = 1'b1;
                sw_en    = 1'b1;
                clr_next = IW'(clr_reg + 1'b1);
                if (clr_reg == LAST_NODE)
                begin
                    state_next = ufsm_pkg::ST_IDLE;
                end
            end
            ufsm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    red_load   = 1'b1;
                    state_next = ufsm_pkg::ST_REDUCE;
                end
            end
            ufsm_pkg::ST_REDUCE:
            begin
                if (red_done)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = red_a;
                    cur_next   = red_a;
                    state_next = ufsm_pkg::ST_WALK_A;
                end
            end
            ufsm_pkg::ST_WALK_A:
            begin
                rd_en = 1'b1;
                if (at_root)
                begin
                    ra_next    = cur_reg;
                    sa_next    = size_q;
                    rd_addr    = red_b;
                    cur_next   = red_b;
                    state_next = ufsm_pkg::ST_WALK_B;
                end
                else
                begin
                    rd_addr  = parent_q;
                    cur_next = parent_q;
                end
            end
            ufsm_pkg::ST_WALK_B:
            begin
                if (at_root)
                begin
                    rb_next    = cur_reg;
                    sb_next    = size_q;
                    state_next = ufsm_pkg::ST_UPDATE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = parent_q;
                    cur_next = parent_q;
                end
            end
            ufsm_pkg::ST_UPDATE:
            begin
                done_next  = 1'b1;
                state_next = ufsm_pkg::ST_IDLE;
                if (same_root)
                begin
                    result_next.root        = ufsm_pkg::IDX_W'(ra_reg);
                    result_next.merged      = 1'b0;
                    result_next.root_size   = sa_reg;
                    result_next.group_count = multi_reg;
                end
                else
                begin
                    // Link the loser under the winner and grow the winner.
                    pw_en      = 1'b1;
                    pw_addr    = lose_root;
                    pw_data    = win_root;
                    sw_en      = 1'b1;
                    sw_addr    = win_root;
                    sw_data    = size_sat;
                    multi_next = multi_upd;
                    result_next.root        = ufsm_pkg::IDX_W'(win_root);
                    result_next.merged      = 1'b1;
                    result_next.root_size   = size_sat;
                    result_next.group_count = multi_upd;
                end
            end
            default:
            begin
                state_next = ufsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ufsm_pkg::ST_CLEAR;
            clr_reg   <= '0;
            multi_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            multi_reg <= multi_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ufsm_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `UFSM_ASSERT_NXT(a_start_sets_busy, start && !busy, busy)
    `UFSM_ASSERT_NXT(a_done_single_cycle, done, !done)
    `UFSM_ASSERT_NOW(a_merge_grows_set, done && result.merged, result.root_size >= 16'd2)
    `UFSM_ASSERT_NOW(a_done_only_idle, done, !busy)

endmodule

/* rtl/core/ufsm_ram.sv */
// Simple dual-port synchronous RAM with a registered read.
module ufsm_ram #(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/ufsm_idx_reduce.sv */
// Iterative reduction of two node indexes modulo the node count.
module ufsm_idx_reduce #(
    parameter int unsigned NODES = 32768,
    parameter int unsigned IW    = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [ufsm_pkg::IDX_W-1:0] a_in,
    input  logic [ufsm_pkg::IDX_W-1:0] b_in,
    output logic                      done,
    output logic [IW-1:0]             a_out,
    output logic [IW-1:0]             b_out
);

    localparam int unsigned VW       = ufsm_pkg::IDX_W;
    localparam int unsigned PER_CYC  = 4;
    localparam int unsigned N_CYC    = (VW + PER_CYC) / PER_CYC;
    localparam int unsigned STEP_W   = $clog2(N_CYC);
    localparam int unsigned THR_W    = 40;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_CYC - 1);

    logic [VW-1:0]     a_reg, a_next;
    logic [VW-1:0]     b_reg, b_next;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;

    // Conditional subtract of NODES shifted up by pos (restoring remainder).
    function automatic logic [VW-1:0] sub_step(input logic [VW-1:0] v, input int pos);
        logic [THR_W-1:0] thr;
        thr = THR_W'(NODES) << pos;
        if (THR_W'(v) >= thr)
            sub_step = VW'(THR_W'(v) - thr);
        else
            sub_step = v;
    endfunction

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        for (int j = 0; j < int'(PER_CYC); j++)
        begin
            a_next = sub_step(a_next, int'(VW) - int'(PER_CYC) * int'(step_reg) - j);
            b_next = sub_step(b_next, int'(VW) - int'(PER_CYC) * int'(step_reg) - j);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
        end
        else if (run_reg)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= STEP_W'(step_reg + 1'b1);
                if (step_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign a_out = IW'(a_reg);
    assign b_out = IW'(b_reg);

endmodule
